// ===== hdl/seven_segment_scan_serializer_top_defines.svh =====
// Assertion macros for the seven-segment scan serializer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SSS_ASSERT_HOLD(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("sss: invariant violated");

// Check that a trigger is followed by a consequence in the next cycle.
`define SSS_ASSERT_NEXT(name, clk, rst_n, trig, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
    else $error("sss: sequence violated");

`endif

// ===== hdl/sss_pkg.sv =====
// Shared types, codes and the glyph table of the seven-segment scan serializer.
// No dependencies.
package sss_pkg;

  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned BIT_W   = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CODE_W-1:0] GLYPH_BLANK = 5'd16;
  localparam logic [BIT_W-1:0]  BIT_FIRST   = 4'd15;
  localparam logic [BIT_W-1:0]  BIT_LAST    = 4'd0;

  typedef struct packed {
    logic serial_bit;
    logic latch_pulse;
  } bit_res_t;

  // Active-low segment pattern; unknown codes show blank.
  function automatic logic [SEG_W-1:0] glyph_segments(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      5'd0:    seg = 8'hC0;
      5'd1:    seg = 8'hF9;
      5'd2:    seg = 8'hA4;
      5'd3:    seg = 8'hB0;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h92;
      5'd6:    seg = 8'h82;
      5'd7:    seg = 8'hF8;
      5'd8:    seg = 8'h80;
      5'd9:    seg = 8'h90;
      5'd10:   seg = 8'h88;
      5'd11:   seg = 8'h83;
      5'd12:   seg = 8'hC6;
      5'd13:   seg = 8'hA1;
      5'd14:   seg = 8'h86;
      5'd15:   seg = 8'h8E;
      5'd16:   seg = 8'hFF;
      5'd17:   seg = 8'hBF;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

endpackage

// ===== hdl/sss_in_if.sv =====
// Input channel: load or tick items with valid/ready handshake.
// Depends on sss_pkg.
interface sss_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [sss_pkg::SLOT_W-1:0]        digit_slot;
  logic [sss_pkg::CODE_W-1:0]        digit_code;

  modport source (output valid, op, digit_slot, digit_code, input ready);
  modport sink   (input valid, op, digit_slot, digit_code, output ready);
endinterface

// ===== hdl/sss_out_if.sv =====
// Output channel: one serial bit with shift and latch strobes per transfer.
// No dependencies.
interface sss_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic shift_pulse;
  logic latch_pulse;

  modport source (output valid, serial_bit, shift_pulse, latch_pulse, input ready);
  modport sink   (input valid, serial_bit, shift_pulse, latch_pulse, output ready);
endinterface

// ===== hdl/seven_segment_scan_serializer_top.sv =====
// A tick transfer's result is registered and shown on the output in the next cycle.
// Throughput: one item per cycle while input ready is high; a load gives no result and moves no scan state.
// Input ready falls only while a result waits and the output is stalled.
// Reset: digit store all zero, scan at word zero, bit fifteen, output empty.
// Depends on sss_pkg, sss_in_if, sss_out_if, sss_digits, sss_scan and the macro header.
`include "seven_segment_scan_serializer_top_defines.svh"

module seven_segment_scan_serializer_top #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sss_in_if.sink        in_i,
  sss_out_if.source     out_o
);

  localparam int unsigned WORD_W = $clog2(DIGIT_COUNT + 1);

  logic                      in_xfer;
  logic                      tick;
  logic                      load;
  logic [WORD_W-1:0]         word;
  logic [sss_pkg::SEG_W-1:0] seg;
  sss_pkg::bit_res_t         res;
  sss_pkg::bit_res_t         res_q;
  logic                      out_valid_q, out_valid_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign tick       = in_xfer && (in_i.op == sss_pkg::OP_TICK);
  assign load       = in_xfer && (in_i.op == sss_pkg::OP_LOAD);

  sss_digits #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .WORD_W      (WORD_W)
  ) u_digits (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load),
    .wr_slot_i (in_i.digit_slot),
    .wr_code_i (in_i.digit_code),
    .rd_word_i (word),
    .seg_o     (seg)
  );

  sss_scan #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .WORD_W      (WORD_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (tick),
    .seg_i     (seg),
    .word_o    (word),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.serial_bit  = res_q.serial_bit;
  assign out_o.shift_pulse = 1'b1;
  assign out_o.latch_pulse = res_q.latch_pulse;

  `SSS_ASSERT_NEXT(a_tick_gives_result, clk_i, rst_ni, tick, out_o.valid)
  `SSS_ASSERT_NEXT(a_load_adds_nothing, clk_i, rst_ni, load && !out_valid_q, !out_o.valid)

endmodule

// ===== hdl/sss_digits.sv =====
// Digit code store with glyph lookup for the word being scanned.
// Depends on sss_pkg.
module sss_digits #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned WORD_W      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [sss_pkg::SLOT_W-1:0]  wr_slot_i,
  input  logic [sss_pkg::CODE_W-1:0]  wr_code_i,
  input  logic [WORD_W-1:0]           rd_word_i,
  output logic [sss_pkg::SEG_W-1:0]   seg_o
);

  logic [sss_pkg::CODE_W-1:0] store_q [DIGIT_COUNT];
  logic [sss_pkg::CODE_W-1:0] rd_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (int'(wr_slot_i) == i) begin
          store_q[i] <= wr_code_i;
        end
      end
    end
  end

  // The blank word past the last digit selects no entry.
  always_comb begin
    rd_code = sss_pkg::GLYPH_BLANK;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (int'(rd_word_i) == i) begin
        rd_code = store_q[i];
      end
    end
  end

  assign seg_o = sss_pkg::glyph_segments(rd_code);

endmodule

// ===== hdl/sss_scan.sv =====
// Frame scan counters and serial bit selection.
// Depends on sss_pkg and the assertion macro header.
`include "seven_segment_scan_serializer_top_defines.svh"

module sss_scan #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned WORD_W      = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [sss_pkg::SEG_W-1:0]  seg_i,
  output logic [WORD_W-1:0]          word_o,
  output sss_pkg::bit_res_t          res_o
);

  localparam logic [WORD_W-1:0] WORD_BLANK = WORD_W'(DIGIT_COUNT);

  logic [WORD_W-1:0]          word_q, word_d;
  logic [sss_pkg::BIT_W-1:0]  bit_q, bit_d;
  logic [sss_pkg::SEG_W-1:0]  sel_byte;
  logic [2*sss_pkg::SEG_W-1:0] word_bits;
  logic                       last;

  assign sel_byte  = (word_q < WORD_BLANK) ? sss_pkg::SEG_W'(1 << word_q) : '0;
  assign word_bits = {seg_i, sel_byte};
  assign last      = (bit_q == sss_pkg::BIT_LAST);

  assign res_o.serial_bit  = word_bits[bit_q];
  assign res_o.latch_pulse = last;
  assign word_o            = word_q;

  always_comb begin
    word_d = word_q;
    bit_d  = bit_q;
    if (advance_i) begin
      if (last) begin
        bit_d  = sss_pkg::BIT_FIRST;
        word_d = (word_q == WORD_BLANK) ? '0 : word_q + WORD_W'(1);
      end else begin
        bit_d = bit_q - sss_pkg::BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      bit_q  <= sss_pkg::BIT_FIRST;
    end else begin
      word_q <= word_d;
      bit_q  <= bit_d;
    end
  end

  `SSS_ASSERT_HOLD(a_word_in_frame, clk_i, rst_ni, word_q <= WORD_BLANK)
  `SSS_ASSERT_NEXT(a_bit_wraps, clk_i, rst_ni, advance_i && last, bit_q == sss_pkg::BIT_FIRST)
  `SSS_ASSERT_NEXT(a_word_holds_mid, clk_i, rst_ni, !(advance_i && last), $stable(word_q))

endmodule

// ===== verif/seven_segment_scan_serializer_top_test.sv =====
// Testbench for seven_segment_scan_serializer_top: random load and tick transfers with random
// idling on both channels; a scoreboard class predicts each serial bit and checks the output.
// Depends on sss_pkg, sss_in_if, sss_out_if and the block's RTL.
`timescale 1ns / 1ps

module seven_segment_scan_serializer_top_test;

  localparam int unsigned DIGITS      = 4;
  localparam int unsigned WORD_COUNT  = DIGITS + 1;
  localparam int unsigned GLYPH_COUNT = 18;
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic serial_bit;
    logic shift_pulse;
    logic latch_pulse;
  } scan_bit_t;

  class scan_bit_board;
    logic [sss_pkg::CODE_W-1:0] shown_codes [DIGITS];
    logic [sss_pkg::SEG_W-1:0]  glyph_lut [GLYPH_COUNT];
    int unsigned                word_idx;
    logic [sss_pkg::BIT_W-1:0]  bit_idx;
    scan_bit_t                  pending_bits [$];
    int unsigned                mismatches;

    function new();
      glyph_lut = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80,
                    8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hFF, 8'hBF};
      foreach (shown_codes[i]) shown_codes[i] = '0;
      word_idx    = 0;
      bit_idx     = sss_pkg::BIT_FIRST;
      mismatches  = 0;
    endfunction

    function logic [sss_pkg::SEG_W-1:0] pattern_of(logic [sss_pkg::CODE_W-1:0] code);
      if (code < GLYPH_COUNT) return glyph_lut[code];
      return 8'hFF;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_item(logic op, logic [sss_pkg::SLOT_W-1:0] slot,
                            logic [sss_pkg::CODE_W-1:0] code);
      logic [2*sss_pkg::SEG_W-1:0] scan_word;
      scan_bit_t                   nxt;
      if (op == sss_pkg::OP_LOAD) begin
        if (slot < DIGITS) shown_codes[slot] = code;
        return;
      end
      if (word_idx < DIGITS)
        scan_word = {pattern_of(shown_codes[word_idx]), sss_pkg::SEG_W'(1 << word_idx)};
      else
        scan_word = {pattern_of(sss_pkg::GLYPH_BLANK), sss_pkg::SEG_W'(0)};
      nxt.serial_bit  = scan_word[bit_idx];
      nxt.shift_pulse = 1'b1;
      nxt.latch_pulse = (bit_idx == sss_pkg::BIT_LAST);
      pending_bits.push_back(nxt);
      if (bit_idx == sss_pkg::BIT_LAST) begin
        bit_idx  = sss_pkg::BIT_FIRST;
        word_idx = (word_idx + 1) % WORD_COUNT;
      end else begin
        bit_idx--;
      end
    endfunction

    task check_bit(scan_bit_t got);
      scan_bit_t want;
      if (pending_bits.size() == 0) begin
        report("output transfer with no expected bit");
        return;
      end
      want = pending_bits.pop_front();
      if (got.serial_bit !== want.serial_bit)
        report($sformatf("serial_bit %b, expected %b", got.serial_bit, want.serial_bit));
      if (got.shift_pulse !== want.shift_pulse)
        report($sformatf("shift_pulse %b, expected %b", got.shift_pulse, want.shift_pulse));
      if (got.latch_pulse !== want.latch_pulse)
        report($sformatf("latch_pulse %b, expected %b", got.latch_pulse, want.latch_pulse));
    endtask

    task check_drained();
      if (pending_bits.size() != 0)
        report($sformatf("%0d expected bits never arrived", pending_bits.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  seven_segment_scan_serializer_top #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  scan_bit_board board = new();

  int unsigned send_idle_max;
  int unsigned drain_idle_max;
  bit          drain_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[seven_segment_scan_serializer_top] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        board.note_item(in_ch.op, in_ch.digit_slot, in_ch.digit_code);
      if (out_ch.valid && out_ch.ready)
        board.check_bit('{out_ch.serial_bit, out_ch.shift_pulse, out_ch.latch_pulse});
    end
  end

  task send_item(logic op, logic [sss_pkg::SLOT_W-1:0] slot,
                 logic [sss_pkg::CODE_W-1:0] code);
    int unsigned gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.digit_slot <= slot;
    in_ch.digit_code <= code;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task send_ticks(int unsigned count);
    repeat (count)
      send_item(sss_pkg::OP_TICK, sss_pkg::SLOT_W'($urandom), sss_pkg::CODE_W'($urandom));
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    int unsigned taken;
    out_ch.ready   <= 1'b0;
    drain_idle_max  = 0;
    taken           = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (drain_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        drain_hold = 1'b0;
      end
      if (taken % 64 == 0) drain_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      gap = $urandom_range(0, drain_idle_max);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    logic                       op;
    logic [sss_pkg::CODE_W-1:0] code;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= sss_pkg::OP_LOAD;
    in_ch.digit_slot <= '0;
    in_ch.digit_code <= '0;
    send_idle_max     = 0;
    drain_hold        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset store shows zeros; then hex extreme, blank, dash and above-dash codes.
    send_ticks(3);
    send_item(sss_pkg::OP_LOAD, 2'd0, 5'd15);
    send_item(sss_pkg::OP_LOAD, 2'd1, 5'd17);
    send_item(sss_pkg::OP_LOAD, 2'd2, 5'd16);
    send_item(sss_pkg::OP_LOAD, 2'd3, 5'd31);
    send_ticks(12);
    // Load into the slot being scanned mid-word; shows from the next frame.
    send_item(sss_pkg::OP_LOAD, 2'd0, 5'd0);
    send_ticks(4);
    send_item(sss_pkg::OP_LOAD, 2'd1, 5'd18);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      if (n == 300) begin
        send_idle_max = 0;
        drain_hold    = 1'b1;
      end
      op   = ($urandom_range(0, 9) < 7) ? sss_pkg::OP_TICK : sss_pkg::OP_LOAD;
      code = $urandom_range(0, 1) ? sss_pkg::CODE_W'($urandom_range(0, 17))
                                  : sss_pkg::CODE_W'($urandom);
      send_item(op, sss_pkg::SLOT_W'($urandom), code);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    for (int unsigned n = 0; n < 5000 && board.pending_bits.size() != 0; n++)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    board.check_drained();
    if (board.mismatches == 0) begin
      $display("[seven_segment_scan_serializer_top] OK");
    end else begin
      $display("[seven_segment_scan_serializer_top] ERROR");
    end
    $finish;
  end

endmodule
